/* sv/iss_pkg.sv */
// shared widths and command codes for the indexed sequence store
`default_nettype none

package iss_pkg;

    localparam int MODE_W      = 2;
    localparam int INDEX_W     = 8;
    localparam int VALUE_W     = 16;
    localparam int ENTRY_W     = 4 * VALUE_W;
    localparam int COUNT_OUT_W = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

`default_nettype wire

/* sv/indexed_sequence_store_unit.sv */
// ordered sequence of four-value entries with insert, read and delete by position
//
// A command is taken when start is high and busy is low; its result appears on the
// o_ ports, marked by o_done for one cycle, and cannot be held off by the receiver.
// The entries live in one memory with a registered read and a single write
// port. Entries move one per cycle through that port: an insert at position p moves
// the entries from p up by one place and then writes the new one (an append only
// writes), a delete at p moves the entries above p down by one place (none for the
// last entry), and a rejected command (bad index, full store, unused mode) strobes
// o_done in the cycle after it is taken. busy is high between a transfer and its o_done.
`default_nettype none

module indexed_sequence_store_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic        [iss_pkg::MODE_W-1:0]     i_mode,
    input  wire logic signed [iss_pkg::INDEX_W-1:0]    i_index,
    input  wire logic signed [iss_pkg::VALUE_W-1:0]    i_value_a,
    input  wire logic signed [iss_pkg::VALUE_W-1:0]    i_value_b,
    input  wire logic signed [iss_pkg::VALUE_W-1:0]    i_value_c,
    input  wire logic signed [iss_pkg::VALUE_W-1:0]    i_value_d,
    output logic                                       o_done,
    output logic                                       o_ok,
    output logic signed      [iss_pkg::VALUE_W-1:0]    o_read_a,
    output logic signed      [iss_pkg::VALUE_W-1:0]    o_read_b,
    output logic signed      [iss_pkg::VALUE_W-1:0]    o_read_c,
    output logic signed      [iss_pkg::VALUE_W-1:0]    o_read_d,
    output logic             [iss_pkg::COUNT_OUT_W-1:0] o_entry_count
);
    import iss_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_PUT,
        S_RD_ISSUE,
        S_RD_DATA,
        S_DEL_SHIFT,
        S_DEL_DRAIN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_end;
    logic [AW-1:0]   r_pos;
    logic            r_wr_pend;
    logic [AW-1:0]   r_wr_addr;
    t_entry          r_new;
    t_entry          r_rdata;
    t_entry          r_mem [CAPACITY];
    logic            r_done;
    logic            r_ok;
    t_entry          r_result;

    // index decode
    logic            idx_m1;
    logic            idx_neg;
    logic [CMPW-1:0] idx_mag;
    logic [CMPW-1:0] count_ext;
    logic            ins_ok;
    logic [AW-1:0]   ins_pos;
    logic            ex_ok;
    logic [AW-1:0]   ex_pos;
    logic [AW-1:0]   last_addr;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_entry          mem_wdata;

    always_comb begin
        idx_m1    = &i_index;
        idx_neg   = i_index[INDEX_W-1];
        idx_mag   = CMPW'(i_index[INDEX_W-2:0]);
        count_ext = CMPW'(r_count);
        last_addr = AW'(r_count - CW'(1));
        ins_ok    = (idx_m1 || (!idx_neg && idx_mag <= count_ext))
                    && (r_count < CW'(CAPACITY));
        ins_pos   = idx_m1 ? AW'(r_count) : AW'(idx_mag);
        ex_ok     = (idx_m1 && r_count != '0) || (!idx_neg && idx_mag < count_ext);
        ex_pos    = idx_m1 ? last_addr : AW'(idx_mag);
    end

    // pending shifted entry has the port, otherwise the new entry goes in
    always_comb begin
        mem_we    = r_wr_pend || (r_state == S_INS_PUT);
        mem_waddr = r_wr_pend ? r_wr_addr : r_pos;
        mem_wdata = r_wr_pend ? r_rdata : r_new;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
            r_ok      <= 1'b0;
            r_result  <= '0;
        end else begin
            r_done    <= 1'b0;
            r_wr_pend <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_new <= {i_value_d, i_value_c, i_value_b, i_value_a};
                        if (i_mode == MODE_INSERT && ins_ok) begin
                            r_pos <= ins_pos;
                            if (CW'(ins_pos) == r_count) begin
                                r_state <= S_INS_PUT;
                            end else begin
                                r_addr  <= last_addr;
                                r_end   <= ins_pos;
                                r_state <= S_INS_SHIFT;
                            end
                        end else if (i_mode == MODE_READ && ex_ok) begin
                            r_addr  <= ex_pos;
                            r_state <= S_RD_ISSUE;
                        end else if (i_mode == MODE_DELETE && ex_ok) begin
                            if (ex_pos == last_addr) begin
                                r_count  <= r_count - CW'(1);
                                r_done   <= 1'b1;
                                r_ok     <= 1'b1;
                                r_result <= '0;
                            end else begin
                                r_addr  <= ex_pos + AW'(1);
                                r_end   <= last_addr;
                                r_state <= S_DEL_SHIFT;
                            end
                        end else begin
                            // rejected command, nothing changes
                            r_done   <= 1'b1;
                            r_ok     <= 1'b0;
                            r_result <= '0;
                        end
                    end
                end
                S_INS_SHIFT: begin
                    // entry read now is written one place up next cycle
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_addr + AW'(1);
                    if (r_addr == r_end) begin
                        r_state <= S_INS_DRAIN;
                    end else begin
                        r_addr <= r_addr - AW'(1);
                    end
                end
                S_INS_DRAIN: begin
                    r_state <= S_INS_PUT;
                end
                S_INS_PUT: begin
                    r_count  <= r_count + CW'(1);
                    r_done   <= 1'b1;
                    r_ok     <= 1'b1;
                    r_result <= '0;
                    r_state  <= S_IDLE;
                end
                S_RD_ISSUE: begin
                    r_state <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    r_done   <= 1'b1;
                    r_ok     <= 1'b1;
                    r_result <= r_rdata;
                    r_state  <= S_IDLE;
                end
                S_DEL_SHIFT: begin
                    // entry read now is written one place down next cycle
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_addr - AW'(1);
                    if (r_addr == r_end) begin
                        r_state <= S_DEL_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DEL_DRAIN: begin
                    r_count  <= r_count - CW'(1);
                    r_done   <= 1'b1;
                    r_ok     <= 1'b1;
                    r_result <= '0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_read_a      = r_result[VALUE_W-1:0];
    assign o_read_b      = r_result[2*VALUE_W-1:VALUE_W];
    assign o_read_c      = r_result[3*VALUE_W-1:2*VALUE_W];
    assign o_read_d      = r_result[4*VALUE_W-1:3*VALUE_W];
    assign o_entry_count = COUNT_OUT_W'(r_count);

endmodule

`default_nettype wire

/* sv/iss_checker.sv */
// port-level checks for the indexed sequence store, bound to the top level
`default_nettype none

module iss_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  start,
    input wire logic                                  busy,
    input wire logic                                  o_done,
    input wire logic                                  o_ok,
    input wire logic signed [iss_pkg::VALUE_W-1:0]    o_read_a,
    input wire logic signed [iss_pkg::VALUE_W-1:0]    o_read_b,
    input wire logic signed [iss_pkg::VALUE_W-1:0]    o_read_c,
    input wire logic signed [iss_pkg::VALUE_W-1:0]    o_read_d,
    input wire logic        [iss_pkg::COUNT_OUT_W-1:0] o_entry_count
);
    import iss_pkg::*;

    // a taken command either finishes at once or keeps the block busy
    a_start_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transfer neither finished nor started work");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transfer");

    // failed commands return zero data and leave the count alone
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_read_a == '0 && o_read_b == '0 && o_read_c == '0
                               && o_read_d == '0 && $stable(o_entry_count)))
        else $error("failed command changed state or returned data");

endmodule

bind indexed_sequence_store_unit iss_checker u_iss_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the indexed sequence store: insert, read and delete by position
`timescale 1ns / 1ps

module testbench;

    import iss_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_CMDS    = 600;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [INDEX_W-1:0] index;
        t_value                    value_a;
        t_value                    value_b;
        t_value                    value_c;
        t_value                    value_d;
        int                        idle_pct;
        bit                        hold_for_drain;
    } t_seq_cmd;

    typedef struct {
        logic                   ok;
        t_value                 read_a;
        t_value                 read_b;
        t_value                 read_c;
        t_value                 read_d;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_seq_reply;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      start     = 1'b0;
    logic [MODE_W-1:0]         i_mode    = '0;
    logic signed [INDEX_W-1:0] i_index   = '0;
    t_value                    i_value_a = '0;
    t_value                    i_value_b = '0;
    t_value                    i_value_c = '0;
    t_value                    i_value_d = '0;

    logic                      busy;
    logic                      o_done;
    logic                      o_ok;
    t_value                    o_read_a;
    t_value                    o_read_b;
    t_value                    o_read_c;
    t_value                    o_read_d;
    logic [COUNT_OUT_W-1:0]    o_entry_count;

    t_seq_cmd   pending_cmds[$];
    t_seq_reply replies_due[$];

    t_entry shadow_entries[CAPACITY];
    int     shadow_len = 0;

    int issued_total = 0;
    int xfer_total   = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;

    indexed_sequence_store_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_index      (i_index),
        .i_value_a    (i_value_a),
        .i_value_b    (i_value_b),
        .i_value_c    (i_value_c),
        .i_value_d    (i_value_d),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_read_a     (o_read_a),
        .o_read_b     (o_read_b),
        .o_read_c     (o_read_c),
        .o_read_d     (o_read_d),
        .o_entry_count(o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // applies one command to the shadow sequence and returns the reply it should give
    function automatic t_seq_reply predict_seq_op(
        input logic [MODE_W-1:0] mode, input logic signed [INDEX_W-1:0] index,
        input t_value va, input t_value vb, input t_value vc, input t_value vd
    );
        t_seq_reply r;
        int ix;
        int pos;
        r = '{ok: 1'b0, read_a: '0, read_b: '0, read_c: '0, read_d: '0, entry_count: '0};
        ix = int'(index);
        case (mode)
            MODE_INSERT: begin
                if ((ix == -1 || (ix >= 0 && ix <= shadow_len)) && shadow_len < CAPACITY) begin
                    pos = (ix == -1) ? shadow_len : ix;
                    for (int k = shadow_len; k > pos; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[pos] = {va, vb, vc, vd};
                    shadow_len++;
                    r.ok = 1'b1;
                end
            end
            MODE_READ, MODE_DELETE: begin
                // -1 selects the last entry, if there is one
                pos = (ix == -1) ? shadow_len - 1 : ix;
                if (pos >= 0 && pos < shadow_len) begin
                    r.ok = 1'b1;
                    if (mode == MODE_READ) begin
                        {r.read_a, r.read_b, r.read_c, r.read_d} = shadow_entries[pos];
                    end else begin
                        for (int k = pos; k + 1 < shadow_len; k++)
                            shadow_entries[k] = shadow_entries[k+1];
                        shadow_len--;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_len[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_cmd(input logic [MODE_W-1:0] mode, input int index,
                             input t_value va, input t_value vb, input t_value vc,
                             input t_value vd, input int idle_pct, input bit hold);
        t_seq_cmd c;
        c.mode           = mode;
        c.index          = index[INDEX_W-1:0];
        c.value_a        = va;
        c.value_b        = vb;
        c.value_c        = vc;
        c.value_d        = vd;
        c.idle_pct       = idle_pct;
        c.hold_for_drain = hold;
        pending_cmds.push_back(c);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return t_value'($urandom);
        endcase
    endfunction

    // driver: a new command goes out once the previous one has been taken
    always @(negedge i_clk) begin
        t_seq_cmd c;
        if (i_rst_n && (!start || xfer_total == issued_total)) begin
            if (pending_cmds.size() != 0
                    && !(pending_cmds[0].hold_for_drain && replies_due.size() != 0)
                    && $urandom_range(99) >= pending_cmds[0].idle_pct) begin
                c = pending_cmds.pop_front();
                start     <= 1'b1;
                i_mode    <= c.mode;
                i_index   <= c.index;
                i_value_a <= c.value_a;
                i_value_b <= c.value_b;
                i_value_c <= c.value_c;
                i_value_d <= c.value_d;
                issued_total++;
            end else begin
                // junk on the payload while idle, the block must not look at it
                start     <= 1'b0;
                i_mode    <= MODE_W'($urandom);
                i_index   <= INDEX_W'($urandom);
                i_value_a <= VALUE_W'($urandom);
                i_value_b <= VALUE_W'($urandom);
                i_value_c <= VALUE_W'($urandom);
                i_value_d <= VALUE_W'($urandom);
            end
        end
    end

    // monitor: checks each result, predicts each transfer, and watches for a hang
    always @(posedge i_clk) begin
        t_seq_reply want;
        if (i_rst_n) begin
            if (o_done) begin
                if (replies_due.size() == 0) begin
                    $error("result strobe with no command outstanding");
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("ok", {31'b0, want.ok}, {31'b0, o_ok});
                    check_field("read_a", want.read_a, o_read_a);
                    check_field("read_b", want.read_b, o_read_b);
                    check_field("read_c", want.read_c, o_read_c);
                    check_field("read_d", want.read_d, o_read_d);
                    check_field("entry_count", want.entry_count, o_entry_count);
                end
            end
            if (start && !busy) begin
                replies_due.push_back(predict_seq_op(i_mode, i_index, i_value_a, i_value_b,
                                                     i_value_c, i_value_d));
                xfer_total++;
            end
            if (o_done || (start && !busy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("testbench failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int gen_len;
        int idle;
        int ins_pct;
        int del_pct;
        int roll;
        int idx;
        logic [MODE_W-1:0] mode;

        // empty store, bad indices, every position class, unused mode
        queue_cmd(MODE_READ,    0,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,   -1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_DELETE, -1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_INSERT,  1,    1, 2, 3, 4, 0, 0);
        queue_cmd(MODE_INSERT, -1, 16'h8000, 16'h7fff, 16'h0000, 16'hffff, 0, 0);
        queue_cmd(MODE_INSERT,  0, 16'h7fff, 16'h8000, 16'hffff, 16'h0000, 0, 0);
        queue_cmd(MODE_INSERT,  2, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 0, 0);
        queue_cmd(MODE_INSERT,  1, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 0, 0);
        queue_cmd(MODE_INSERT,  5,    7, 7, 7, 7, 0, 0);
        queue_cmd(MODE_INSERT, -2,    7, 7, 7, 7, 0, 0);
        queue_cmd(MODE_INSERT, -128,  7, 7, 7, 7, 0, 0);
        queue_cmd(MODE_INSERT, 127,   7, 7, 7, 7, 0, 0);
        queue_cmd(MODE_READ,    0,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,   -1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,    3,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,    4,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,   -2,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,  127,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_UNUSED,  0,    9, 9, 9, 9, 0, 0);
        queue_cmd(MODE_DELETE,  1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_DELETE,  0,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_DELETE, -1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_DELETE,  1,    0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_DELETE, -128,  0, 0, 0, 0, 0, 0);
        queue_cmd(MODE_READ,    0,    0, 0, 0, 0, 0, 0);

        // random part alternates fill and drain stretches so the store runs full and empty
        gen_len = 1;
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            idle    = (k < 150) ? 0 : (k < 300) ? 86 : (k < 450) ? 8 : 0;
            ins_pct = ((k / 120) % 2 == 0) ? 70 : 15;
            del_pct = ((k / 120) % 2 == 0) ? 10 : 65;
            if ($urandom_range(99) < 10) begin
                // commands that must be rejected
                mode = MODE_W'($urandom_range(3));
                if (mode == MODE_UNUSED)
                    idx = $urandom_range(255);
                else if ($urandom_range(1) == 0)
                    idx = -int'($urandom_range(128, 2));
                else if (mode == MODE_INSERT)
                    idx = $urandom_range(127, gen_len + 1);
                else
                    idx = $urandom_range(127, gen_len);
            end else begin
                roll = $urandom_range(99);
                if (roll < ins_pct) begin
                    mode = MODE_INSERT;
                    idx  = ($urandom_range(3) == 0) ? -1 : $urandom_range(gen_len, 0);
                    if (gen_len < CAPACITY)
                        gen_len++;
                end else begin
                    mode = (roll < ins_pct + del_pct) ? MODE_DELETE : MODE_READ;
                    if (gen_len == 0 || $urandom_range(3) == 0)
                        idx = -1;
                    else
                        idx = $urandom_range(gen_len - 1, 0);
                    if (mode == MODE_DELETE && gen_len > 0)
                        gen_len--;
                end
            end
            queue_cmd(mode, idx, pick_value(), pick_value(), pick_value(), pick_value(),
                      idle, k % 150 == 0);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || xfer_total != issued_total
               || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
